[rtl/postfix_regex_to_enfa_defines.svh]
// Assertion macros for the regex-to-automaton RTL.
`ifndef POSTFIX_REGEX_TO_ENFA_DEFINES_SVH
`define POSTFIX_REGEX_TO_ENFA_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRX_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRX_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/prx2nfa_pkg.sv]
// Shared types, constants and the operator decoder for the regex-to-automaton block.
package prx2nfa_pkg;

  // Default sizing
  localparam int STACK_DEPTH_DEF = 128;
  localparam int NODE_LIMIT_DEF  = 1024;

  // Fixed field widths
  localparam int CHAR_W      = 8;
  localparam int OUT_NODE_W  = 10;
  localparam int OUT_TOTAL_W = 11;
  localparam int TDATA_W     = 64;
  localparam int FIELDS_W    = 2 * OUT_NODE_W + CHAR_W + 2 + 2 * OUT_NODE_W + OUT_TOTAL_W;
  localparam int PAD_W       = TDATA_W - FIELDS_W;

  // Operator characters
  localparam logic [CHAR_W-1:0] CH_CAT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ALT  = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

  typedef enum logic [1:0] {
    OP_LIT,
    OP_CAT,
    OP_ALT,
    OP_STAR
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } eng_state_e;

  typedef enum logic {
    KIND_TRANS   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One result record
  typedef struct packed {
    logic                   item_kind;
    logic [OUT_NODE_W-1:0]  src_state;
    logic [OUT_NODE_W-1:0]  dst_state;
    logic [CHAR_W-1:0]      label_char;
    logic                   is_epsilon;
    logic                   valid_expr;
    logic [OUT_NODE_W-1:0]  start_node;
    logic [OUT_NODE_W-1:0]  final_node;
    logic [OUT_TOTAL_W-1:0] node_total;
    logic                   last_of_run;
  } rec_t;

  // Character class
  function automatic op_e decode_op(input logic [CHAR_W-1:0] c);
    op_e op;
    case (c)
      CH_CAT:  op = OP_CAT;
      CH_ALT:  op = OP_ALT;
      CH_STAR: op = OP_STAR;
      default: op = OP_LIT;
    endcase
    return op;
  endfunction

endpackage

[rtl/prx2nfa_stack.sv]
// Fragment stack memory: one write port, one read port, registered read data.
module prx2nfa_stack
  import prx2nfa_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NODE_LIMIT  = NODE_LIMIT_DEF,
  localparam int ADDR_W = $clog2(STACK_DEPTH),
  localparam int NODE_W = $clog2(NODE_LIMIT)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_W-1:0]     wr_addr_i,
  input  logic [2*NODE_W-1:0]   wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_W-1:0]     rd_addr_i,
  output logic [2*NODE_W-1:0]   rd_data_o
);

  logic [2*NODE_W-1:0] mem_q [STACK_DEPTH];
  logic [2*NODE_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/prx2nfa_outbuf.sv]
// Two-entry result queue between the construction engine and the output stream.
module prx2nfa_outbuf
  import prx2nfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  rec_t rec_i,
  input  logic rec_valid_i,
  output logic rec_ready_o,
  output rec_t rec_o,
  output logic rec_valid_o,
  input  logic rec_ready_i
);

  rec_t       ent_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign rec_ready_o = (cnt_q != 2'd2);
  assign rec_valid_o = (cnt_q != 2'd0);
  assign rec_o       = ent_q[rptr_q];

  assign push = rec_valid_i && rec_ready_o;
  assign pop  = rec_valid_o && rec_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= rec_i;
    end
  end

endmodule

[rtl/prx2nfa_engine.sv]
// Thompson construction engine: top two fragments in flops, the rest in the stack memory.
module prx2nfa_engine
  import prx2nfa_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NODE_LIMIT  = NODE_LIMIT_DEF,
  localparam int ADDR_W = $clog2(STACK_DEPTH),
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1),
  localparam int NODE_W = $clog2(NODE_LIMIT),
  localparam int CNT_W  = $clog2(NODE_LIMIT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pending character
  input  logic                in_valid_i,
  input  logic [CHAR_W-1:0]   in_char_i,
  input  logic                in_end_i,
  output logic                take_o,
  // result records
  output rec_t                rec_o,
  output logic                rec_valid_o,
  input  logic                rec_ready_i,
  // stack memory
  output logic                mem_wr_en_o,
  output logic [ADDR_W-1:0]   mem_wr_addr_o,
  output logic [2*NODE_W-1:0] mem_wr_data_o,
  output logic                mem_rd_en_o,
  output logic [ADDR_W-1:0]   mem_rd_addr_o,
  input  logic [2*NODE_W-1:0] mem_rd_data_i
);

  `include "postfix_regex_to_enfa_defines.svh"

  // Control state
  eng_state_e       state_q, state_d;
  logic [2:0]       idx_q, idx_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [CNT_W-1:0] next_q, next_d;
  logic             err_q, err_d;
  logic             refill_q, refill_d;

  // Top-of-stack fragments
  logic [NODE_W-1:0] t0_st_q, t0_en_q, t1_st_q, t1_en_q;
  logic [NODE_W-1:0] t0_st_d, t0_en_d, t1_st_d, t1_en_d;

  // Per-character operands, loaded at start
  op_e                    op_q;
  logic [CHAR_W-1:0]      char_q;
  logic [NODE_W-1:0]      s_q, e_q, a_st_q, a_en_q, b_st_q, b_en_q;
  logic [2:0]             nrec_q;
  logic                   end_q;
  logic                   sum_valid_q;
  logic [OUT_NODE_W-1:0]  sum_st_q, sum_fi_q;
  logic [OUT_TOTAL_W-1:0] sum_tot_q;

  // Start-cycle decode
  op_e               op;
  logic              start, room, ok, do_op;
  logic [NODE_W-1:0] s_node, e_node;
  logic [LVL_W-1:0]  lvl_m2, lvl_m3, level_n;
  logic [CNT_W-1:0]  next_n;
  logic              err_n, sum_valid_n;
  logic [2:0]        nrec_n, tot_n;

  // Emit-side selection
  logic [2:0]        tot_q;
  logic              is_sum, is_last;
  logic [NODE_W-1:0] src, dst;

  assign op     = decode_op(in_char_i);
  assign start  = (state_q == ST_IDLE) && in_valid_i;
  assign take_o = start;
  assign room   = ({1'b0, next_q} + (CNT_W + 1)'(2)) <= (CNT_W + 1)'(NODE_LIMIT);
  assign s_node = next_q[NODE_W-1:0];
  assign e_node = s_node + NODE_W'(1);
  assign lvl_m2 = level_q - LVL_W'(2);
  assign lvl_m3 = level_q - LVL_W'(3);

  // Operand check per operator
  always_comb begin
    case (op)
      OP_CAT:  ok = (level_q >= LVL_W'(2));
      OP_ALT:  ok = (level_q >= LVL_W'(2)) && room;
      OP_STAR: ok = (level_q >= LVL_W'(1)) && room;
      OP_LIT:  ok = (level_q < LVL_W'(STACK_DEPTH)) && room;
      default: ok = 1'b0;
    endcase
  end

  assign do_op = start && !err_q && ok;

  // Stack update for the character being started
  always_comb begin
    level_n       = level_q;
    next_n        = next_q;
    err_n         = err_q;
    t0_st_d       = t0_st_q;
    t0_en_d       = t0_en_q;
    t1_st_d       = t1_st_q;
    t1_en_d       = t1_en_q;
    refill_d      = 1'b0;
    nrec_n        = 3'd0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = lvl_m2[ADDR_W-1:0];
    mem_wr_data_o = {t1_st_q, t1_en_q};
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = lvl_m3[ADDR_W-1:0];

    // fragment under the top returns from memory after a pop
    if (refill_q) begin
      t1_st_d = mem_rd_data_i[2*NODE_W-1:NODE_W];
      t1_en_d = mem_rd_data_i[NODE_W-1:0];
    end

    if (start && !err_q && !ok) begin
      err_n = 1'b1;
    end

    if (do_op) begin
      case (op)
        OP_LIT: begin
          nrec_n      = 3'd1;
          mem_wr_en_o = (level_q >= LVL_W'(2));
          t1_st_d     = t0_st_q;
          t1_en_d     = t0_en_q;
          t0_st_d     = s_node;
          t0_en_d     = e_node;
          level_n     = level_q + LVL_W'(1);
          next_n      = next_q + CNT_W'(2);
        end
        OP_CAT: begin
          nrec_n      = 3'd1;
          t0_st_d     = t1_st_q;
          level_n     = level_q - LVL_W'(1);
          mem_rd_en_o = (level_q >= LVL_W'(3));
          refill_d    = mem_rd_en_o;
        end
        OP_ALT: begin
          nrec_n      = 3'd4;
          t0_st_d     = s_node;
          t0_en_d     = e_node;
          level_n     = level_q - LVL_W'(1);
          next_n      = next_q + CNT_W'(2);
          mem_rd_en_o = (level_q >= LVL_W'(3));
          refill_d    = mem_rd_en_o;
        end
        OP_STAR: begin
          nrec_n  = 3'd4;
          t0_st_d = s_node;
          t0_en_d = e_node;
          next_n  = next_q + CNT_W'(2);
        end
        default: begin
          nrec_n = 3'd0;
        end
      endcase
    end

    sum_valid_n = !err_n && (level_n == LVL_W'(1));
    tot_n       = nrec_n + {2'b00, in_end_i};

    // end of expression clears level, node count and error for the next one
    level_d = level_n;
    next_d  = next_n;
    err_d   = err_n;
    if (start && in_end_i) begin
      level_d = '0;
      next_d  = '0;
      err_d   = 1'b0;
    end
  end

  // Sequencer
  assign tot_q   = nrec_q + {2'b00, end_q};
  assign is_sum  = (idx_q == nrec_q);
  assign is_last = (idx_q == tot_q - 3'd1);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (start && (tot_n != 3'd0)) begin
          state_d = ST_EMIT;
          idx_d   = 3'd0;
        end
      end
      ST_EMIT: begin
        if (rec_ready_i) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Transition endpoints by operator and record number
  always_comb begin
    src = s_q;
    dst = e_q;
    case (op_q)
      OP_LIT: begin
        src = s_q;
        dst = e_q;
      end
      OP_CAT: begin
        src = a_en_q;
        dst = b_st_q;
      end
      OP_ALT: begin
        case (idx_q[1:0])
          2'd0:    begin src = s_q;    dst = a_st_q; end
          2'd1:    begin src = s_q;    dst = b_st_q; end
          2'd2:    begin src = a_en_q; dst = e_q;    end
          default: begin src = b_en_q; dst = e_q;    end
        endcase
      end
      OP_STAR: begin
        case (idx_q[1:0])
          2'd0:    begin src = s_q;    dst = a_st_q; end
          2'd1:    begin src = s_q;    dst = e_q;    end
          2'd2:    begin src = a_en_q; dst = a_st_q; end
          default: begin src = a_en_q; dst = e_q;    end
        endcase
      end
      default: begin
        src = s_q;
        dst = e_q;
      end
    endcase
  end

  // Record assembly
  always_comb begin
    rec_o             = '0;
    rec_o.last_of_run = is_last;
    if (is_sum) begin
      rec_o.item_kind  = KIND_SUMMARY;
      rec_o.valid_expr = sum_valid_q;
      rec_o.start_node = sum_st_q;
      rec_o.final_node = sum_fi_q;
      rec_o.node_total = sum_tot_q;
    end else begin
      rec_o.item_kind  = KIND_TRANS;
      rec_o.src_state  = OUT_NODE_W'(src);
      rec_o.dst_state  = OUT_NODE_W'(dst);
      rec_o.is_epsilon = (op_q != OP_LIT);
      rec_o.label_char = (op_q == OP_LIT) ? char_q : '0;
    end
  end

  assign rec_valid_o = (state_q == ST_EMIT);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= 3'd0;
      level_q  <= '0;
      next_q   <= '0;
      err_q    <= 1'b0;
      refill_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      level_q  <= level_d;
      next_q   <= next_d;
      err_q    <= err_d;
      refill_q <= refill_d;
    end
  end

  // Fragment and operand registers
  always_ff @(posedge clk_i) begin
    t0_st_q <= t0_st_d;
    t0_en_q <= t0_en_d;
    t1_st_q <= t1_st_d;
    t1_en_q <= t1_en_d;
    if (start) begin
      op_q        <= op;
      char_q      <= in_char_i;
      s_q         <= s_node;
      e_q         <= e_node;
      a_st_q      <= (op == OP_STAR) ? t0_st_q : t1_st_q;
      a_en_q      <= (op == OP_STAR) ? t0_en_q : t1_en_q;
      b_st_q      <= t0_st_q;
      b_en_q      <= t0_en_q;
      nrec_q      <= nrec_n;
      end_q       <= in_end_i;
      sum_valid_q <= sum_valid_n;
      sum_st_q    <= sum_valid_n ? OUT_NODE_W'(t0_st_d) : '0;
      sum_fi_q    <= sum_valid_n ? OUT_NODE_W'(t0_en_d) : '0;
      sum_tot_q   <= OUT_TOTAL_W'(next_n);
    end
  end

  // Checks
  `PRX_ASSERT_SAME(a_refill_before_start, start, !refill_q, "pop refill still pending at start")
  `PRX_ASSERT_SAME(a_level_bound, 1'b1, level_q <= LVL_W'(STACK_DEPTH), "stack level past depth")
  `PRX_ASSERT_SAME(a_node_count, 1'b1, !next_q[0] && (next_q <= CNT_W'(NODE_LIMIT)), "bad node count")
  `PRX_ASSERT_NEXT(a_end_clears, start && in_end_i, (level_q == '0) && (next_q == '0) && !err_q, "no clear")

endmodule

[rtl/postfix_regex_to_enfa.sv]
// A character's first record reaches the master side through the input holding register, the
// engine's operand registers and the result queue.
// The engine takes a new character only once it has emitted every record of the previous one
// (one for a literal or concat, four for union or star, plus the summary on the last character);
// its emit sequencer gives one record per cycle while the result queue has room.
// Reset: asynchronous, clears level, node counter, error and handshake state; the fragment
// stack memory is not cleared, entries are written before they are read.
module postfix_regex_to_enfa
  import prx2nfa_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int NODE_LIMIT  = NODE_LIMIT_DEF,
  localparam int ADDR_W = $clog2(STACK_DEPTH),
  localparam int NODE_W = $clog2(NODE_LIMIT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input characters
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
  input  logic               s_axis_tlast,   // end_of_expr
  // result records
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // src_state, dst_state, label_char, is_epsilon,
                                             // valid_expr, start_node, final_node, node_total
  output logic               m_axis_tuser,   // item_kind
  output logic               m_axis_tlast    // last_of_run
);

  // Input holding register
  logic              in_full_q, in_full_d;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_end_q;
  logic              in_take, in_acc;

  // Engine and memory nets
  rec_t                eng_rec, out_rec;
  logic                eng_rec_valid, eng_rec_ready;
  logic                mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0]   mem_wr_addr, mem_rd_addr;
  logic [2*NODE_W-1:0] mem_wr_data, mem_rd_data;

  assign s_axis_tready = !in_full_q || in_take;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_full_d = in_full_q;
    if (in_acc) begin
      in_full_d = 1'b1;
    end else if (in_take) begin
      in_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_char_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  // Construction engine
  prx2nfa_engine #(
    .STACK_DEPTH (STACK_DEPTH),
    .NODE_LIMIT  (NODE_LIMIT)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_full_q),
    .in_char_i     (in_char_q),
    .in_end_i      (in_end_q),
    .take_o        (in_take),
    .rec_o         (eng_rec),
    .rec_valid_o   (eng_rec_valid),
    .rec_ready_i   (eng_rec_ready),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  // Fragment stack below the top two entries
  prx2nfa_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .NODE_LIMIT  (NODE_LIMIT)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Result queue
  prx2nfa_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (eng_rec),
    .rec_valid_i (eng_rec_valid),
    .rec_ready_o (eng_rec_ready),
    .rec_o       (out_rec),
    .rec_valid_o (m_axis_tvalid),
    .rec_ready_i (m_axis_tready)
  );

  // Stream packing
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_rec.node_total, out_rec.final_node,
                         out_rec.start_node, out_rec.valid_expr, out_rec.is_epsilon,
                         out_rec.label_char, out_rec.dst_state, out_rec.src_state};
  assign m_axis_tuser = out_rec.item_kind;
  assign m_axis_tlast = out_rec.last_of_run;

endmodule

[tb/enfa_checker.sv]
// Checker for the regex-to-automaton block: follows requests, predicts records, compares results.
module enfa_checker
  import prx2nfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TDATA_W-1:0] m_axis_tdata,
  input  logic               m_axis_tuser,
  input  logic               m_axis_tlast,
  output int                 mismatch_count_o,
  output int                 pending_o
);

  localparam int FRAG_DEPTH = STACK_DEPTH_DEF;
  localparam int STATE_CAP  = NODE_LIMIT_DEF;

  // Shadow of the construction state
  logic [OUT_NODE_W-1:0] frag_start [FRAG_DEPTH];
  logic [OUT_NODE_W-1:0] frag_end   [FRAG_DEPTH];
  int                    frag_level;
  int                    node_count;
  logic                  build_failed;

  rec_t awaited_recs[$];
  int   mismatches;

  function automatic rec_t trans_rec(input logic [OUT_NODE_W-1:0] src,
                                     input logic [OUT_NODE_W-1:0] dst,
                                     input logic [CHAR_W-1:0] lab,
                                     input logic eps);
    rec_t r;
    r            = '0;
    r.item_kind  = KIND_TRANS;
    r.src_state  = src;
    r.dst_state  = dst;
    r.label_char = lab;
    r.is_epsilon = eps;
    return r;
  endfunction

  function automatic logic room_for_pair();
    return (node_count + 2) <= STATE_CAP;
  endfunction

  // Work out the records one character causes and queue them in order
  task automatic predict_records(input logic [CHAR_W-1:0] ch, input logic fin);
    rec_t                  batch [5];
    int                    n;
    logic                  ok;
    logic [OUT_NODE_W-1:0] ls, le, rs, re, ns, ne;
    n  = 0;
    ns = node_count[OUT_NODE_W-1:0];
    ne = ns + OUT_NODE_W'(1);
    if (!build_failed) begin
      case (ch)
        CH_CAT: begin
          if (frag_level < 2) begin
            build_failed = 1'b1;
          end else begin
            rs = frag_start[frag_level-1];
            re = frag_end[frag_level-1];
            le = frag_end[frag_level-2];
            batch[n] = trans_rec(le, rs, '0, 1'b1);
            n++;
            frag_level--;
            frag_end[frag_level-1] = re;
          end
        end
        CH_ALT: begin
          if (frag_level < 2 || !room_for_pair()) begin
            build_failed = 1'b1;
          end else begin
            rs = frag_start[frag_level-1];
            re = frag_end[frag_level-1];
            ls = frag_start[frag_level-2];
            le = frag_end[frag_level-2];
            node_count += 2;
            batch[0] = trans_rec(ns, ls, '0, 1'b1);
            batch[1] = trans_rec(ns, rs, '0, 1'b1);
            batch[2] = trans_rec(le, ne, '0, 1'b1);
            batch[3] = trans_rec(re, ne, '0, 1'b1);
            n = 4;
            frag_level--;
            frag_start[frag_level-1] = ns;
            frag_end[frag_level-1]   = ne;
          end
        end
        CH_STAR: begin
          if (frag_level < 1 || !room_for_pair()) begin
            build_failed = 1'b1;
          end else begin
            ls = frag_start[frag_level-1];
            le = frag_end[frag_level-1];
            node_count += 2;
            batch[0] = trans_rec(ns, ls, '0, 1'b1);
            batch[1] = trans_rec(ns, ne, '0, 1'b1);
            batch[2] = trans_rec(le, ls, '0, 1'b1);
            batch[3] = trans_rec(le, ne, '0, 1'b1);
            n = 4;
            frag_start[frag_level-1] = ns;
            frag_end[frag_level-1]   = ne;
          end
        end
        default: begin
          if (frag_level >= FRAG_DEPTH || !room_for_pair()) begin
            build_failed = 1'b1;
          end else begin
            node_count += 2;
            batch[n] = trans_rec(ns, ne, ch, 1'b0);
            n++;
            frag_start[frag_level] = ns;
            frag_end[frag_level]   = ne;
            frag_level++;
          end
        end
      endcase
    end

    // Summary closes the expression and clears the build
    if (fin) begin
      ok                  = !build_failed && frag_level == 1;
      batch[n]            = '0;
      batch[n].item_kind  = KIND_SUMMARY;
      batch[n].valid_expr = ok;
      batch[n].start_node = ok ? frag_start[0] : '0;
      batch[n].final_node = ok ? frag_end[0] : '0;
      batch[n].node_total = node_count[OUT_TOTAL_W-1:0];
      n++;
      frag_level   = 0;
      node_count   = 0;
      build_failed = 1'b0;
    end

    if (n > 0) batch[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) awaited_recs.push_back(batch[i]);
  endtask

  task automatic check_field(input string field, input logic [OUT_TOTAL_W-1:0] want,
                             input logic [OUT_TOTAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Compare results first, then record the new request
  always @(posedge clk_i or negedge rst_ni) begin : track
    rec_t got;
    rec_t want;
    if (!rst_ni) begin
      frag_level   = 0;
      node_count   = 0;
      build_failed = 1'b0;
      mismatches   = 0;
      awaited_recs.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.item_kind   = m_axis_tuser;
        got.src_state   = m_axis_tdata[9:0];
        got.dst_state   = m_axis_tdata[19:10];
        got.label_char  = m_axis_tdata[27:20];
        got.is_epsilon  = m_axis_tdata[28];
        got.valid_expr  = m_axis_tdata[29];
        got.start_node  = m_axis_tdata[39:30];
        got.final_node  = m_axis_tdata[49:40];
        got.node_total  = m_axis_tdata[60:50];
        got.last_of_run = m_axis_tlast;
        if (awaited_recs.size() == 0) begin
          $display("%0t: unexpected result, expected none got tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = awaited_recs.pop_front();
          check_field("item_kind", OUT_TOTAL_W'(want.item_kind),
                      OUT_TOTAL_W'(got.item_kind));
          check_field("src_state", OUT_TOTAL_W'(want.src_state),
                      OUT_TOTAL_W'(got.src_state));
          check_field("dst_state", OUT_TOTAL_W'(want.dst_state),
                      OUT_TOTAL_W'(got.dst_state));
          check_field("label_char", OUT_TOTAL_W'(want.label_char),
                      OUT_TOTAL_W'(got.label_char));
          check_field("is_epsilon", OUT_TOTAL_W'(want.is_epsilon),
                      OUT_TOTAL_W'(got.is_epsilon));
          check_field("valid_expr", OUT_TOTAL_W'(want.valid_expr),
                      OUT_TOTAL_W'(got.valid_expr));
          check_field("start_node", OUT_TOTAL_W'(want.start_node),
                      OUT_TOTAL_W'(got.start_node));
          check_field("final_node", OUT_TOTAL_W'(want.final_node),
                      OUT_TOTAL_W'(got.final_node));
          check_field("node_total", want.node_total, got.node_total);
          check_field("last_of_run", OUT_TOTAL_W'(want.last_of_run),
                      OUT_TOTAL_W'(got.last_of_run));
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_records(s_axis_tdata, s_axis_tlast);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= awaited_recs.size();
  end

endmodule

[tb/testbench.sv]
// Top of the regex-to-automaton testbench: clock, reset, character stimulus and verdict.
module testbench;
  import prx2nfa_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  int                 fail_count;
  int                 pending;
  int                 chars_sent = 0;
  bit                 quiet_phase = 1'b0;
  logic [7:0]         expr_chars[$];

  postfix_regex_to_enfa DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  enfa_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid    (s_tvalid),
    .s_axis_tready    (s_tready),
    .s_axis_tdata     (s_tdata),
    .s_axis_tlast     (s_tlast),
    .m_axis_tvalid    (m_tvalid),
    .m_axis_tready    (m_tready),
    .m_axis_tdata     (m_tdata),
    .m_axis_tuser     (m_tuser),
    .m_axis_tlast     (m_tlast),
    .mismatch_count_o (fail_count),
    .pending_o        (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // Result side stalls at random, never during the quiet stretch
  initial begin
    forever begin
      @(posedge clk);
      m_tready <= quiet_phase || ($urandom_range(0, 99) >= 18);
    end
  end

  function automatic logic [7:0] pick_symbol();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_CAT || c == CH_ALT || c == CH_STAR);
    return c;
  endfunction

  // One character request; ready is sampled at the falling edge
  task automatic send_char(input logic [7:0] ch, input logic fin);
    logic taken;
    if (!quiet_phase && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      do @(posedge clk);
      while ($urandom_range(0, 99) < 18);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= fin;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    chars_sent++;
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_chars.size(); i++) send_char(expr_chars[i], i == expr_chars.size() - 1);
  endtask

  // Hold off until every predicted record has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk);
    while (pending != 0);
    @(posedge clk);
  endtask

  // Random well-formed postfix expression of a few symbols
  task automatic build_wellformed();
    int depth;
    int lits;
    int roll;
    expr_chars.delete();
    depth = 0;
    lits  = $urandom_range(1, 8);
    while (lits > 0 || depth > 1) begin
      roll = $urandom_range(0, 99);
      if (depth >= 1 && roll < 15) begin
        expr_chars.push_back(CH_STAR);
      end else if (lits > 0 && (depth < 2 || roll < 55)) begin
        expr_chars.push_back(pick_symbol());
        depth++;
        lits--;
      end else begin
        expr_chars.push_back(roll[0] ? CH_CAT : CH_ALT);
        depth--;
      end
    end
  endtask

  // Random mix of symbols and operators, mostly malformed
  task automatic build_noise();
    int len;
    int roll;
    expr_chars.delete();
    len = $urandom_range(1, 10);
    repeat (len) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)      expr_chars.push_back(pick_symbol());
      else if (roll < 55) expr_chars.push_back(CH_CAT);
      else if (roll < 70) expr_chars.push_back(CH_ALT);
      else if (roll < 85) expr_chars.push_back(CH_STAR);
      else                expr_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int rand_base;
    int expr_idx;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: symbol 'e', code extremes, every operator, error paths
    expr_chars = '{8'h65};
    send_expr();
    expr_chars = '{8'h00, 8'hFF, CH_ALT};
    send_expr();
    expr_chars = '{8'h61, CH_STAR, 8'h62, CH_CAT};
    send_expr();
    // concat on an empty stack
    expr_chars = '{CH_CAT};
    send_expr();
    // union with one fragment, then the error sticks
    expr_chars = '{8'h61, CH_ALT, 8'h62, CH_STAR};
    send_expr();
    // star on an empty stack: no records until the summary
    expr_chars = '{CH_STAR, 8'h63};
    send_expr();
    // two fragments left over
    expr_chars = '{8'h41, 8'h42};
    send_expr();
    expr_chars = '{8'h7F, 8'h80, CH_CAT, CH_STAR};
    send_expr();
    drain();

    // Random expressions, with a quiet stretch and one hold-off midway
    rand_base = chars_sent;
    expr_idx  = 0;
    while (chars_sent - rand_base < 480) begin
      quiet_phase = (chars_sent - rand_base >= 150) && (chars_sent - rand_base < 270);
      if ($urandom_range(0, 99) < 75) build_wellformed();
      else                            build_noise();
      send_expr();
      expr_idx++;
      if (expr_idx == 40) drain();
    end
    quiet_phase = 1'b0;

    // Stack overflow: one symbol past a full stack
    expr_chars.delete();
    repeat (STACK_DEPTH_DEF + 1) expr_chars.push_back(pick_symbol());
    expr_chars.push_back(CH_CAT);
    send_expr();

    // Out of state numbers: fill every state, then ask for two more
    expr_chars.delete();
    expr_chars.push_back(pick_symbol());
    repeat (NODE_LIMIT_DEF / 2 - 2) expr_chars.push_back(CH_STAR);
    expr_chars.push_back(pick_symbol());
    expr_chars.push_back(CH_CAT);
    expr_chars.push_back(CH_STAR);
    send_expr();

    // Wind down and give the verdict
    s_tvalid <= 1'b0;
    do @(negedge clk);
    while (pending != 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
